// File: hw/rtl/kbrf_pkg.sv
// Shared types, codes and the key word packing function for the keyboard byte ring FIFO.
package kbrf_pkg;

    localparam int BYTE_W    = 8;
    localparam int KEY_BYTES = 3;
    localparam int KEY_W     = KEY_BYTES * BYTE_W;
    localparam int LEN_W     = 2;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    // one stored entry: up to three packed bytes, oldest in the low byte
    typedef struct packed {
        t_len             len;
        logic [KEY_W-1:0] bytes;
    } t_entry;

    // drop zero bytes and pack the rest down, keeping their order
    function automatic t_entry pack_key(input logic [KEY_W-1:0] word);
        t_entry e;
        t_len   pos;
        e   = '0;
        pos = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (word[i*BYTE_W +: BYTE_W] != '0) begin
                e.bytes[pos*BYTE_W +: BYTE_W] = word[i*BYTE_W +: BYTE_W];
                pos = pos + 1'b1;
            end
        end
        e.len = pos;
        return e;
    endfunction

endpackage

// File: hw/rtl/kbrf_ram.sv
// Entry memory with one write port and a registered read port with write bypass.
module kbrf_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  kbrf_pkg::t_entry    i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output kbrf_pkg::t_entry    o_rdata
);

    kbrf_pkg::t_entry r_mem [DEPTH];
    kbrf_pkg::t_entry r_rdata;
    kbrf_pkg::t_entry r_byp_data;
    logic             r_byp;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_byp      <= i_we && (i_waddr == i_raddr);
        r_byp_data <= i_wdata;
    end

    assign o_rdata = r_byp ? r_byp_data : r_rdata;

endmodule

// File: hw/rtl/keyboard_byte_ring_fifo.sv
// Top level of the keyboard byte ring FIFO: beat stages, ring control and result register.
//
//  channel  | dir | tdata            | tuser
//  s_axis   | in  | key_word[23:0]   | kind[0]
//  m_axis   | out | read_byte[7:0]   | has_data[0]
//
// One beat per cycle sustained while the result is taken; an input beat passes the
// input register, then the result register, before its result beat.
// Each push stores its non-zero bytes, as many as fit, as one entry on the single memory write port.
// Reset is synchronous; pointers and byte count clear at once, no memory sweep.
// A stalled result holds; the input stage keeps taking beats while the result
// register is free or being drained.
module keyboard_byte_ring_fifo #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // key_word[23:0]
    input  logic [0:0]  i_s_axis_tuser,   // kind[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // read_byte[7:0]
    output logic [0:0]  o_m_axis_tuser    // has_data[0]
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    logic                            r_in_valid;
    kbrf_pkg::t_kind                 r_kind;
    logic [kbrf_pkg::KEY_W-1:0]      r_key;
    logic                            r_out_valid;
    logic [kbrf_pkg::BYTE_W-1:0]     r_out_byte;
    logic                            r_out_has;
    logic [AW-1:0]                   r_rd_ptr;
    logic [AW-1:0]                   r_wr_ptr;
    logic [AW-1:0]                   r_count;
    kbrf_pkg::t_len                  r_sub;

    logic [AW-1:0]                   n_rd_ptr;
    logic [AW-1:0]                   n_wr_ptr;
    logic [AW-1:0]                   n_count;
    kbrf_pkg::t_len                  n_sub;
    logic [kbrf_pkg::BYTE_W-1:0]     n_out_byte;

    logic                            w_adv;
    logic                            w_proc;
    kbrf_pkg::t_entry                w_packed;
    kbrf_pkg::t_entry                w_wdata;
    kbrf_pkg::t_entry                w_head;
    logic [AW-1:0]                   w_free;
    kbrf_pkg::t_len                  w_take;
    logic                            w_we;
    logic                            w_head_done;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign w_proc          = r_in_valid && w_adv;
    assign o_s_axis_tready = !r_in_valid || w_adv;

    assign w_packed = kbrf_pkg::pack_key(r_key);
    assign w_free   = LAST - r_count;

    always_comb begin
        if ((AW + 2)'(w_packed.len) > (AW + 2)'(w_free)) begin
            w_take = kbrf_pkg::t_len'(w_free);
        end else begin
            w_take = w_packed.len;
        end
    end

    assign w_wdata.len   = w_take;
    assign w_wdata.bytes = w_packed.bytes;
    assign w_head_done   = (r_sub + 1'b1) == w_head.len;

    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_sub      = r_sub;
        n_out_byte = '0;
        w_we       = 1'b0;
        if (w_proc) begin
            if (r_kind == kbrf_pkg::KIND_POP) begin
                if (r_count != '0) begin
                    n_out_byte = w_head.bytes[r_sub*kbrf_pkg::BYTE_W +: kbrf_pkg::BYTE_W];
                    n_count    = r_count - 1'b1;
                    if (w_head_done) begin
                        n_rd_ptr = f_inc(r_rd_ptr);
                        n_sub    = '0;
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end else begin
                if (w_take != '0) begin
                    w_we     = 1'b1;
                    n_wr_ptr = f_inc(r_wr_ptr);
                    n_count  = r_count + AW'(w_take);
                end
            end
        end
    end

    kbrf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_wdata),
        .i_raddr (n_rd_ptr),
        .o_rdata (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_sub       <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_sub    <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_kind <= kbrf_pkg::t_kind'(i_s_axis_tuser[0]);
            r_key  <= i_s_axis_tdata;
        end
        if (w_proc) begin
            r_out_byte <= n_out_byte;
            r_out_has  <= (n_count != '0);
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_byte;
    assign o_m_axis_tuser[0] = r_out_has;

    a_has_data_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] == (r_count != '0)))
        else $error("has_data disagrees with byte count");

    a_pop_gives_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_kind == kbrf_pkg::KIND_POP && r_count != '0) |=> (o_m_axis_tdata != '0))
        else $error("pop from non-empty ring returned zero byte");

    a_push_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_kind == kbrf_pkg::KIND_PUSH) |=> ($stable(r_rd_ptr) && $stable(r_sub)))
        else $error("push moved the read side");

    a_push_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_kind == kbrf_pkg::KIND_PUSH) |=> (o_m_axis_tdata == '0))
        else $error("push beat returned a non-zero byte");

endmodule
